// ----- design/ffcba_pkg.sv -----
// ffcba_pkg: shared types and constants of the first-fit block allocator
// no dependencies; imported by every module of the block

package ffcba_pkg;

    localparam int SIZE_W  = 24;   // byte_size
    localparam int BB_W    = 13;   // block_bytes
    localparam int DBC_W   = 11;   // data_block_count
    localparam int DIR_W   = 10;   // current_directory, parent_entry
    localparam int ENTRY_W = 11;   // entry counter
    localparam int ID_W    = 10;   // entry_id
    localparam int FIRST_W = 11;   // first_block
    localparam int TOTAL_W = 12;   // block_total
    localparam int FREE_W  = 11;   // free_left
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // divider: dividend is byte_size + block_bytes - 1
    localparam int DVD_W  = SIZE_W + 1;
    localparam int DVS_W  = BB_W;
    localparam int QCNT_W = $clog2(DVD_W);

    typedef enum logic [1:0] {
        ST_CREATED    = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2
    } t_status;

    localparam logic [1:0] REG_BLOCK_BYTES = 2'd0;
    localparam logic [1:0] REG_DATA_BLOCKS = 2'd1;
    localparam logic [1:0] REG_CUR_DIR     = 2'd2;

    typedef struct packed {
        logic scan;
        logic mark;
    } t_eng_req;

    typedef struct packed {
        logic ready;
        logic done;
        logic found;
    } t_eng_rsp;

endpackage

// ----- design/ffcba_div.sv -----
// ffcba_div: restoring divider, one quotient bit per cycle
// depends on ffcba_pkg

module ffcba_div import ffcba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quot;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    w_shift;
    logic [DVS_W:0]    w_diff;
    logic              w_ge;

    always_comb begin
        w_shift = {r_rem, r_quot[DVD_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
                r_quot <= {r_quot[DVD_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- design/ffcba_scan.sv -----
// ffcba_scan: block used map memory with clear pass, first-fit scan and run marking
// depends on ffcba_pkg

module ffcba_scan import ffcba_pkg::*; #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_eng_req                         i_req,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  i_need,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  i_limit,
    output t_eng_rsp                         o_rsp,
    output logic [$clog2(MAX_BLOCKS)-1:0]    o_start
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {E_CLEAR, E_IDLE, E_SCAN, E_MARK} t_state;

    t_state          r_state;
    logic            r_map [MAX_BLOCKS];
    logic            r_q;
    logic [CW-1:0]   r_ia;
    logic            r_pv;
    logic [AW-1:0]   r_pi;
    logic [CW-1:0]   r_run;
    logic [CW-1:0]   r_need;
    logic [CW-1:0]   r_limit;
    logic [AW-1:0]   r_start;
    logic [AW-1:0]   r_wa;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic            r_found;

    logic            w_we;
    logic            w_wd;
    logic [CW-1:0]   w_run_inc;
    logic [CW-1:0]   w_start;
    logic            w_hit;
    logic            w_last;

    always_comb begin
        w_we      = (r_state == E_CLEAR) || (r_state == E_MARK);
        w_wd      = (r_state == E_MARK);
        w_run_inc = r_run + 1'b1;
        w_start   = CW'(r_pi) + 1'b1 - r_need;
        w_hit     = r_pv && !r_q && (w_run_inc == r_need);
        w_last    = r_pv && (CW'(r_pi) == r_limit - 1'b1);
    end

    // map memory: up to one write and one read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[r_wa] <= w_wd;
        end
        r_q <= r_map[r_ia[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_CLEAR;
            r_wa    <= '0;
            r_ia    <= '0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_CLEAR: begin
                    r_wa <= r_wa + 1'b1;
                    if (r_wa == AW'(MAX_BLOCKS - 1)) begin
                        r_state <= E_IDLE;
                    end
                end
                E_IDLE: begin
                    if (i_req.scan) begin
                        r_need  <= i_need;
                        r_limit <= i_limit;
                        r_ia    <= '0;
                        r_pv    <= 1'b0;
                        r_run   <= '0;
                        r_state <= E_SCAN;
                    end else if (i_req.mark) begin
                        r_wa    <= r_start;
                        r_cnt   <= r_need;
                        r_state <= E_MARK;
                    end
                end
                E_SCAN: begin
                    // read issue runs ahead of the run check, which uses the registered map read
                    if (r_pv) begin
                        r_run <= r_q ? '0 : w_run_inc;
                    end
                    if (w_hit || w_last) begin
                        r_start <= w_start[AW-1:0];
                        r_found <= w_hit;
                        r_done  <= 1'b1;
                        r_pv    <= 1'b0;
                        r_state <= E_IDLE;
                    end else if (r_ia < r_limit) begin
                        r_ia <= r_ia + 1'b1;
                        r_pv <= 1'b1;
                        r_pi <= r_ia[AW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                end
                E_MARK: begin
                    r_wa  <= r_wa + 1'b1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    always_comb begin
        o_rsp.ready = (r_state == E_IDLE);
        o_rsp.done  = r_done;
        o_rsp.found = r_found;
        o_start     = r_start;
    end

endmodule

// ----- design/first_fit_contiguous_block_allocator.sv -----
// first_fit_contiguous_block_allocator: top level, config registers, request sequencer
// depends on ffcba_pkg, ffcba_div, ffcba_scan
//
// channel   direction  handshake              payload
// s_*       in         s_tvalid / s_tready    tuser: kind; tdata: byte_size
// m_*       out        m_tvalid / m_tready    tuser: status; tdata: record fields
// apb       in         psel, penable, pwrite  block_bytes, data_block_count, current_directory
//
// folder: a result without divide or map work; file: divide, then first-fit scan over up to n blocks,
// n the active data blocks (one map read per cycle while scanning), then one map write per marked block
// reset starts a clear pass over the MAX_BLOCKS map entries; s_tready is low during it
// one request at a time; the next is taken while a result still waits on m_*

module first_fit_contiguous_block_allocator import ffcba_pkg::*; #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // byte_size[23:0]
    input  logic [0:0]         s_tuser,   // kind[0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // entry_id, first_block, block_total, parent_entry, free_left, pad
    output logic [1:0]         m_tuser,   // status[1:0]
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_SCAN, S_MARK, S_DONE} t_state;

    t_state               r_state;
    logic [BB_W-1:0]      r_block_bytes;
    logic [DBC_W-1:0]     r_data_blocks;
    logic [DIR_W-1:0]     r_cur_dir;
    logic [CW-1:0]        r_used;
    logic [ENTRY_W-1:0]   r_entry;
    logic [CW-1:0]        r_need;
    t_status              r_st;
    logic [ID_W-1:0]      r_id;
    logic [FIRST_W-1:0]   r_first;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_m_tvalid;
    logic [1:0]           r_m_tuser;
    logic [55:0]          r_m_tdata;

    logic                 w_cfg_wr;
    logic                 w_in_acc;
    logic [BB_W-1:0]      w_bb;
    logic [CW-1:0]        w_n;
    logic                 w_full;
    logic                 w_fits;
    logic [FREE_W-1:0]    w_free;
    logic                 w_out_free;
    logic                 w_div_start;
    logic [DVD_W-1:0]     w_dividend;
    logic                 w_div_done;
    logic [DVD_W-1:0]     w_quot;
    t_eng_req             w_eng_req;
    t_eng_rsp             w_eng_rsp;
    logic [AW-1:0]        w_eng_start;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BB_W'(512);
            r_data_blocks <= DBC_W'(1024);
            r_cur_dir     <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_BLOCK_BYTES: r_block_bytes <= pwdata[BB_W-1:0];
                REG_DATA_BLOCKS: r_data_blocks <= pwdata[DBC_W-1:0];
                REG_CUR_DIR:     r_cur_dir     <= pwdata[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BLOCK_BYTES: prdata = PDATA_W'(r_block_bytes);
            REG_DATA_BLOCKS: prdata = PDATA_W'(r_data_blocks);
            REG_CUR_DIR:     prdata = PDATA_W'(r_cur_dir);
            default:         prdata = '0;
        endcase
    end

    // request datapath
    always_comb begin
        w_in_acc    = s_tvalid && s_tready;
        w_bb        = (r_block_bytes == '0) ? BB_W'(1) : r_block_bytes;
        if (32'(r_data_blocks) > 32'(MAX_BLOCKS)) begin
            w_n = CW'(MAX_BLOCKS);
        end else begin
            w_n = CW'(r_data_blocks);
        end
        w_full      = 32'(r_entry) >= 32'(w_n);
        w_fits      = (w_quot != '0) && (w_quot <= DVD_W'(w_n));
        if (32'(w_n) > 32'(r_used)) begin
            w_free = FREE_W'(32'(w_n) - 32'(r_used));
        end else begin
            w_free = '0;
        end
        w_out_free  = !r_m_tvalid || m_tready;
        w_dividend  = DVD_W'(s_tdata) + DVD_W'(w_bb) - DVD_W'(1);
        w_div_start = w_in_acc && s_tuser[0];
        w_eng_req.scan = (r_state == S_DIV) && w_div_done && w_fits;
        w_eng_req.mark = (r_state == S_SCAN) && w_eng_rsp.done && w_eng_rsp.found && !w_full;
    end

    ffcba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_bb),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    ffcba_scan #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_eng_req),
        .i_need  (w_quot[CW-1:0]),
        .i_limit (w_n),
        .o_rsp   (w_eng_rsp),
        .o_start (w_eng_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_entry    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_id    <= '0;
                        r_first <= '1;
                        r_total <= '0;
                        if (s_tuser[0]) begin
                            r_state <= S_DIV;
                        end else begin
                            if (w_full) begin
                                r_st <= ST_TABLE_FULL;
                            end else begin
                                r_st    <= ST_CREATED;
                                r_id    <= r_entry[ID_W-1:0];
                                r_entry <= r_entry + 1'b1;
                                r_total <= '1;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_need <= w_quot[CW-1:0];
                        if (w_fits) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_st    <= ST_NO_SPACE;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_eng_rsp.done) begin
                        if (!w_eng_rsp.found) begin
                            r_st    <= ST_NO_SPACE;
                            r_state <= S_DONE;
                        end else if (w_full) begin
                            r_st    <= ST_TABLE_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_first <= FIRST_W'(w_eng_start);
                            r_total <= TOTAL_W'(r_need);
                            r_state <= S_MARK;
                        end
                    end
                end
                S_MARK: begin
                    if (w_eng_rsp.done) begin
                        r_st    <= ST_CREATED;
                        r_id    <= r_entry[ID_W-1:0];
                        r_entry <= r_entry + 1'b1;
                        r_used  <= r_used + r_need;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tuser  <= r_st;
                        r_m_tdata  <= {2'b00, w_free, r_cur_dir, r_total, r_first, r_id};
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (r_state == S_IDLE) && w_eng_rsp.ready;
    assign m_tvalid = r_m_tvalid;
    assign m_tuser  = r_m_tuser;
    assign m_tdata  = r_m_tdata;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(MAX_BLOCKS))
        else $error("used block count beyond map size");

    a_entry_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_entry == $past(r_entry)) || (r_entry == $past(r_entry) + 1'b1))
        else $error("entry count moved by more than one");

    a_eng_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eng_rsp.done |-> ((r_state == S_SCAN) || (r_state == S_MARK)))
        else $error("map engine finished outside scan or mark");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide phase");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (m_tvalid && (r_state == S_IDLE)))
        else $error("finished result not presented");
`endif

endmodule
